// ===== rtl/pssr_pkg.sv =====
// pssr_pkg: types and constants shared by the slot reset sequencer files
// no dependencies; compile first
`default_nettype none

package pssr_pkg;

    // sequence phases, as reported on the result channel
    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_POWER_OFF   = 3'd1,
        PH_RESET_START = 3'd2,
        PH_RESET_HOLD  = 3'd3,
        PH_LINK_START  = 3'd4,
        PH_DELAY_FINAL = 3'd5,
        PH_POLLING     = 3'd6
    } phase_t;

    // input item kinds
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_HOT  = 2'd1;
    localparam logic [1:0] KIND_FUND = 2'd2;

    // link notice codes
    localparam logic [1:0] NOTICE_NONE = 2'd0;
    localparam logic [1:0] NOTICE_DOWN = 2'd1;
    localparam logic [1:0] NOTICE_UP   = 2'd2;

    // completion status codes
    localparam logic [1:0] STAT_NONE       = 2'd0;
    localparam logic [1:0] STAT_OK         = 2'd1;
    localparam logic [1:0] STAT_TIMEOUT    = 2'd2;
    localparam logic [1:0] STAT_UNEXPECTED = 2'd3;

    // power indicator codes
    localparam logic [1:0] IND_ON  = 2'd1;
    localparam logic [1:0] IND_OFF = 2'd3;

    // field widths
    localparam int MS_W    = 11;
    localparam int RETRY_W = 8;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 11;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_LINK_REPORT = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_POWER_CTRL  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_POWER_WAIT  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_RESET_HOLD  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_SETTLE      = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_POLL_IVL    = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_POLL_RETRY  = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_NO_REPORT   = 3'd7;

    // configuration reset values
    localparam logic [MS_W-1:0]    RST_POWER_WAIT = 11'd50;
    localparam logic [MS_W-1:0]    RST_RESET_HOLD = 11'd250;
    localparam logic [MS_W-1:0]    RST_SETTLE     = 11'd1800;
    localparam logic [MS_W-1:0]    RST_POLL_IVL   = 11'd20;
    localparam logic [RETRY_W-1:0] RST_POLL_RETRY = 8'd250;
    localparam logic [MS_W-1:0]    RST_NO_REPORT  = 11'd1000;

    // configuration register set
    typedef struct packed {
        logic               link_report_capable;
        logic               power_control_capable;
        logic [MS_W-1:0]    power_wait_ms;
        logic [MS_W-1:0]    reset_hold_ms;
        logic [MS_W-1:0]    settle_ms;
        logic [MS_W-1:0]    poll_interval_ms;
        logic [RETRY_W-1:0] poll_retries;
        logic [MS_W-1:0]    no_report_wait_ms;
    } cfg_t;

    // one input beat
    typedef struct packed {
        logic [1:0] kind;
        logic       presence;
        logic       link_active;
    } item_t;

    // one result beat
    typedef struct packed {
        logic [2:0] phase;
        logic       secondary_reset;
        logic       power_off;
        logic [1:0] power_indicator;
        logic       link_enable_pulse;
        logic [1:0] link_notice;
        logic [1:0] status;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/pssr_if.sv =====
// pssr_item_if, pssr_result_if: valid/ready channels of the slot reset sequencer
// no dependencies
`default_nettype none

interface pssr_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       presence;
    logic       link_active;

    modport source (output valid, output kind, output presence, output link_active,
                    input ready);
    modport sink   (input valid, input kind, input presence, input link_active,
                    output ready);
endinterface

interface pssr_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] phase;
    logic       secondary_reset;
    logic       power_off;
    logic [1:0] power_indicator;
    logic       link_enable_pulse;
    logic [1:0] link_notice;
    logic [1:0] status;

    modport source (output valid, output phase, output secondary_reset, output power_off,
                    output power_indicator, output link_enable_pulse,
                    output link_notice, output status, input ready);
    modport sink   (input valid, input phase, input secondary_reset, input power_off,
                    input power_indicator, input link_enable_pulse,
                    input link_notice, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/pssr_fsm.sv =====
// pssr_fsm: sequencer state registers and one-beat step logic
// depends on pssr_pkg
`default_nettype none

module pssr_fsm
    import pssr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire item_t   item,
    input  wire cfg_t    cfg,
    output      result_t result
);

    phase_t             cur_phase_reg, cur_phase_next;
    logic [MS_W-1:0]    wait_left_reg, wait_left_next;
    logic [RETRY_W-1:0] retries_left_reg, retries_left_next;
    logic               power_off_reg, power_off_next;
    logic               reset_level_reg, reset_level_next;
    logic [1:0]         indicator_reg, indicator_next;
    logic               pulse;
    logic [1:0]         notice;
    logic [1:0]         status;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_phase_reg    <= PH_IDLE;
            wait_left_reg    <= '0;
            retries_left_reg <= '0;
            power_off_reg    <= 1'b0;
            reset_level_reg  <= 1'b0;
            indicator_reg    <= IND_ON;
        end
        else if (step)
        begin
            cur_phase_reg    <= cur_phase_next;
            wait_left_reg    <= wait_left_next;
            retries_left_reg <= retries_left_next;
            power_off_reg    <= power_off_next;
            reset_level_reg  <= reset_level_next;
            indicator_reg    <= indicator_next;
        end
    end

    // next state for one beat
    always_comb
    begin
        cur_phase_next    = cur_phase_reg;
        wait_left_next    = wait_left_reg;
        retries_left_next = retries_left_reg;
        power_off_next    = power_off_reg;
        reset_level_next  = reset_level_reg;
        indicator_next    = indicator_reg;
        pulse             = 1'b0;
        notice            = NOTICE_NONE;
        status            = STAT_NONE;

        case (item.kind)
            KIND_TICK:
            begin
                if (cur_phase_reg != PH_IDLE)
                begin
                    if (wait_left_reg > 11'd1)
                    begin
                        wait_left_next = wait_left_reg - 11'd1;
                    end
                    else
                    begin
                        // wait expired: run the phase action
                        wait_left_next = '0;
                        case (cur_phase_reg)
                            PH_POWER_OFF:
                            begin
                                if (cfg.power_control_capable)
                                begin
                                    power_off_next = 1'b0;
                                    indicator_next = IND_ON;
                                end
                                cur_phase_next = PH_RESET_START;
                                wait_left_next = cfg.power_wait_ms;
                            end
                            PH_RESET_START:
                            begin
                                reset_level_next = 1'b1;
                                cur_phase_next   = PH_RESET_HOLD;
                                wait_left_next   = cfg.reset_hold_ms;
                            end
                            PH_RESET_HOLD:
                            begin
                                reset_level_next = 1'b0;
                                cur_phase_next   = PH_LINK_START;
                                wait_left_next   = cfg.settle_ms;
                            end
                            PH_LINK_START:
                            begin
                                if (!item.presence)
                                begin
                                    cur_phase_next = PH_IDLE;
                                    status         = STAT_OK;
                                end
                                else
                                begin
                                    pulse = 1'b1;
                                    if (!cfg.link_report_capable)
                                    begin
                                        cur_phase_next = PH_DELAY_FINAL;
                                        wait_left_next = cfg.no_report_wait_ms;
                                    end
                                    else
                                    begin
                                        retries_left_next = cfg.poll_retries;
                                        cur_phase_next    = PH_POLLING;
                                        wait_left_next    = cfg.poll_interval_ms;
                                    end
                                end
                            end
                            PH_DELAY_FINAL:
                            begin
                                notice         = NOTICE_UP;
                                cur_phase_next = PH_IDLE;
                                status         = STAT_OK;
                            end
                            PH_POLLING:
                            begin
                                if (item.link_active)
                                begin
                                    notice         = NOTICE_UP;
                                    cur_phase_next = PH_IDLE;
                                    status         = STAT_OK;
                                end
                                else if (retries_left_reg == '0)
                                begin
                                    cur_phase_next = PH_IDLE;
                                    status         = STAT_TIMEOUT;
                                end
                                else
                                begin
                                    retries_left_next = retries_left_reg - 8'd1;
                                    wait_left_next    = cfg.poll_interval_ms;
                                end
                            end
                            default:
                            begin
                                cur_phase_next = PH_IDLE;
                                status         = STAT_NONE;
                            end
                        endcase
                    end
                end
            end
            KIND_HOT, KIND_FUND:
            begin
                if (cur_phase_reg != PH_IDLE)
                begin
                    // request while busy aborts
                    cur_phase_next = PH_IDLE;
                    wait_left_next = '0;
                    status         = STAT_UNEXPECTED;
                end
                else if (item.kind == KIND_HOT)
                begin
                    notice           = NOTICE_DOWN;
                    reset_level_next = 1'b1;
                    cur_phase_next   = PH_RESET_HOLD;
                    wait_left_next   = cfg.reset_hold_ms;
                end
                else
                begin
                    notice         = NOTICE_DOWN;
                    wait_left_next = cfg.power_wait_ms;
                    if (!cfg.power_control_capable || !power_off_reg)
                    begin
                        if (cfg.power_control_capable)
                        begin
                            power_off_next = 1'b1;
                            indicator_next = IND_OFF;
                        end
                        cur_phase_next = PH_POWER_OFF;
                    end
                    else
                    begin
                        power_off_next = 1'b0;
                        indicator_next = IND_ON;
                        cur_phase_next = PH_RESET_START;
                    end
                end
            end
            default:
            begin
                // unused kind leaves the state alone
            end
        endcase
    end

    // result fields after this beat
    always_comb
    begin
        result.phase             = cur_phase_next;
        result.secondary_reset   = reset_level_next;
        result.power_off         = power_off_next;
        result.power_indicator   = indicator_next;
        result.link_enable_pulse = pulse;
        result.link_notice       = notice;
        result.status            = status;
    end

endmodule

`default_nettype wire

// ===== rtl/pcie_slot_reset_sequencer_core.sv =====
// pcie_slot_reset_sequencer_core: top level with input, result and config registers
// depends on pssr_pkg, pssr_if.sv, pssr_fsm
`default_nettype none

// channel   dir  handshake       payload
// item      in   valid/ready     kind, presence, link_active
// result    out  valid/ready     phase, secondary_reset, power_off, power_indicator,
//                                link_enable_pulse, link_notice, status
// config    in   wr_en           wr_index, wr_data
//
// one beat per clock while the result channel does not stall; a beat is captured in the
// input register and its result is then registered in the result register
// the sequencer state updates as the beat moves from input to result register
// a stalled result holds the input register; the item channel stays open while
// the input register is empty or moving
// reset clears state and loads the default config values

module pcie_slot_reset_sequencer_core
    import pssr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    pssr_item_if.sink              item,
    pssr_result_if.source          result,
    input  wire logic              wr_en,
    input  wire logic [CIDX_W-1:0] wr_index,
    input  wire logic [CDATA_W-1:0] wr_data
);

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t step_result;
    logic    advance;
    logic    step;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_report_capable   <= 1'b1;
            cfg_reg.power_control_capable <= 1'b1;
            cfg_reg.power_wait_ms         <= RST_POWER_WAIT;
            cfg_reg.reset_hold_ms         <= RST_RESET_HOLD;
            cfg_reg.settle_ms             <= RST_SETTLE;
            cfg_reg.poll_interval_ms      <= RST_POLL_IVL;
            cfg_reg.poll_retries          <= RST_POLL_RETRY;
            cfg_reg.no_report_wait_ms     <= RST_NO_REPORT;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_LINK_REPORT: cfg_reg.link_report_capable   <= wr_data[0];
                CFG_POWER_CTRL:  cfg_reg.power_control_capable <= wr_data[0];
                CFG_POWER_WAIT:  cfg_reg.power_wait_ms         <= wr_data[MS_W-1:0];
                CFG_RESET_HOLD:  cfg_reg.reset_hold_ms         <= wr_data[MS_W-1:0];
                CFG_SETTLE:      cfg_reg.settle_ms             <= wr_data[MS_W-1:0];
                CFG_POLL_IVL:    cfg_reg.poll_interval_ms      <= wr_data[MS_W-1:0];
                CFG_POLL_RETRY:  cfg_reg.poll_retries          <= wr_data[RETRY_W-1:0];
                CFG_NO_REPORT:   cfg_reg.no_report_wait_ms     <= wr_data[MS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // pipeline flow control
    assign advance    = !out_valid_reg || result.ready;
    assign step       = in_valid_reg && advance;
    assign item.ready = !in_valid_reg || advance;

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_item_reg.kind        <= item.kind;
            in_item_reg.presence    <= item.presence;
            in_item_reg.link_active <= item.link_active;
        end
    end

    pssr_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (step_result)
    );

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= step_result;
        end
    end

    // result beat
    assign result.valid             = out_valid_reg;
    assign result.phase             = out_reg.phase;
    assign result.secondary_reset   = out_reg.secondary_reset;
    assign result.power_off         = out_reg.power_off;
    assign result.power_indicator   = out_reg.power_indicator;
    assign result.link_enable_pulse = out_reg.link_enable_pulse;
    assign result.link_notice       = out_reg.link_notice;
    assign result.status            = out_reg.status;

endmodule

`default_nettype wire
